// ===== rtl/mpsd_pkg.sv =====
package mpsd_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  // request operations
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVAL  = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  // broadcast control to every cell
  typedef struct packed {
    logic eval;   // capture compare flags
    logic ins;    // open a slot and drop the value in
    logic del;    // close the slot of the first match
  } cell_ctl_t;

endpackage

// ===== rtl/min_priority_store_with_delete.sv =====
// Channel | Direction | Ports                                   | Handshake
// in      | input     | in_func, in_value                       | in_valid / in_stall
// out     | output    | out_status, out_min_value,              | out_valid / out_stall
//         |           | out_is_empty, out_count                 |
//
// Each request passes through S_EVAL, which captures the compare flags in every
// cell of the sorted chain, then S_APPLY, which shifts the chain and registers
// the result. A new request is taken in the shift cycle, so the next request
// enters as one ends; the compare-then-shift pair in the cell chain sets this.
// rst_n is synchronous, active low; it empties the store (count to zero).
// A stalled result holds the shift cycle, and with it the input side.
module min_priority_store_with_delete (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic signed [mpsd_pkg::VAL_W-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic signed [mpsd_pkg::VAL_W-1:0]   out_min_value,
  output logic                                out_is_empty,
  output logic [6:0]                          out_count
);
  import mpsd_pkg::*;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    func_r;
  logic signed [VAL_W-1:0] value_r;

  logic                    out_valid_r;
  logic [1:0]              status_r, status_nxt;
  logic signed [VAL_W-1:0] min_r, min_nxt;

  logic                    in_accept;
  logic                    out_free;
  logic                    apply_go;
  logic                    full;
  logic                    found;
  cell_ctl_t               ctl;

  // chain wiring
  logic signed [VAL_W-1:0] cell_val   [CAPACITY];
  logic signed [VAL_W-1:0] cell_nxt   [CAPACITY];
  logic signed [VAL_W-1:0] left_val   [CAPACITY];
  logic signed [VAL_W-1:0] right_val  [CAPACITY];
  logic [CAPACITY-1:0]     cell_le;
  logic [CAPACITY-1:0]     cell_eq;
  logic [CAPACITY-1:0]     left_le;
  logic [CAPACITY-1:0]     occupied;

  // output register frees up when empty or being drained this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign apply_go  = (state_r == S_APPLY) && out_free;
  assign in_stall  = !((state_r == S_IDLE) || apply_go);
  assign in_accept = in_valid && !in_stall;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign found = |cell_eq;   // empty store leaves every eq flag low

  assign ctl.eval = (state_r == S_EVAL);
  assign ctl.ins  = apply_go && (func_r == FUNC_INSERT) && !full;
  assign ctl.del  = apply_go && (func_r == FUNC_DELETE) && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
    assign occupied[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_val[i] = value_r;
      assign left_le[i]  = 1'b1;
    end else begin : g_body
      assign left_val[i] = cell_val[i-1];
      assign left_le[i]  = cell_le[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val[i] = cell_val[i];
    end else begin : g_mid
      assign right_val[i] = cell_val[i+1];
    end

    mpsd_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (occupied[i]),
      .req_value (value_r),
      .left_val  (left_val[i]),
      .left_le   (left_le[i]),
      .right_val (right_val[i]),
      .val       (cell_val[i]),
      .val_nxt   (cell_nxt[i]),
      .le        (cell_le[i]),
      .eq        (cell_eq[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (apply_go) state_nxt = in_accept ? S_EVAL : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result of the request in the shift cycle
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    if (func_r == FUNC_INSERT) begin
      if (full) status_nxt = ST_FULL;
      else      count_nxt  = count_r + CNT_W'(1);
    end else begin
      if (found) count_nxt  = count_r - CNT_W'(1);
      else       status_nxt = ST_MISSING;
    end
    // head of the chain after the shift is the minimum
    min_nxt = (count_nxt == '0) ? '0 : cell_nxt[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (apply_go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r  <= in_func;
      value_r <= in_value;
    end
    if (apply_go) begin
      status_r <= status_nxt;
      min_r    <= min_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_min_value = min_r;
  assign out_is_empty  = (count_r == '0);
  assign out_count     = 7'(count_r);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow occupancy");

  a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_APPLY))
    else $error("result raised outside shift cycle");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && (count_r >= CNT_W'(2)) |-> cell_val[0] <= cell_val[1])
    else $error("chain head out of order");
`endif

endmodule

// ===== rtl/mpsd_cell.sv =====
module mpsd_cell (
  input  logic                                 clk,
  input  mpsd_pkg::cell_ctl_t                  ctl,
  input  logic                                 occupied,
  input  logic signed [mpsd_pkg::VAL_W-1:0]    req_value,
  input  logic signed [mpsd_pkg::VAL_W-1:0]    left_val,
  input  logic                                 left_le,
  input  logic signed [mpsd_pkg::VAL_W-1:0]    right_val,
  output logic signed [mpsd_pkg::VAL_W-1:0]    val,
  output logic signed [mpsd_pkg::VAL_W-1:0]    val_nxt,
  output logic                                 le,
  output logic                                 eq
);
  import mpsd_pkg::*;

  logic signed [VAL_W-1:0] val_r;
  logic                    le_r;
  logic                    lt_r;
  logic                    eq_r;

  // entries are sorted, so le and lt form prefixes along the chain
  always_comb begin
    val_nxt = val_r;
    if (ctl.ins && !le_r) begin
      val_nxt = left_le ? req_value : left_val;
    end else if (ctl.del && !lt_r) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (ctl.eval) begin
      le_r <= occupied && (val_r <= req_value);
      lt_r <= occupied && (val_r <  req_value);
      eq_r <= occupied && (val_r == req_value);
    end
  end

  assign val = val_r;
  assign le  = le_r;
  assign eq  = eq_r;

endmodule
